// File: sv/mqsb_pkg.sv
package mqsb_pkg;

    // Default sizes of the shared store.
    localparam int NUM_QUEUES_DEF = 4;
    localparam int SEG_DEPTH_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the request and response fields.
    localparam int KIND_W   = 1;
    localparam int QIDX_W   = 2;
    localparam int PUSH_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POP_W    = 32;

    // Depth of the command queue between the front and the back.
    localparam int CMD_DEPTH = 2;
    localparam int CQ_AW     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CQ_CW     = $clog2(CMD_DEPTH + 1);

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_status status;
        logic    wr;
        logic    rd;
    } t_cmd_ctl;

endpackage

// File: sv/mqsb_if.sv
// Request channel: one enqueue or dequeue per transaction.
interface mqsb_req_if;
    import mqsb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [QIDX_W-1:0]        queue_index;
    logic signed [PUSH_W-1:0] push_value;

    modport source (output valid, kind, queue_index, push_value, input ready);
    modport sink   (input valid, kind, queue_index, push_value, output ready);
endinterface

// Response channel: one result per request.
interface mqsb_rsp_if;
    import mqsb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [POP_W-1:0] pop_value;

    modport source (output valid, status, pop_value, input ready);
    modport sink   (input valid, status, pop_value, output ready);
endinterface

// File: sv/mqsb_front.sv
module mqsb_front #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int SEG_DEPTH  = mqsb_pkg::SEG_DEPTH_DEF,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(NUM_QUEUES * SEG_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mqsb_req_if.sink              i_req,
    output logic                  o_push_valid,
    output mqsb_pkg::t_cmd_ctl    o_push_ctl,
    output logic [ADDR_W-1:0]     o_push_addr,
    output logic [DATA_WIDTH-1:0] o_push_data,
    input  logic                  i_push_ready
);
    import mqsb_pkg::*;

    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW  = $clog2(SEG_DEPTH + 1);

    logic [PW-1:0]  r_head [NUM_QUEUES];
    logic [PW-1:0]  r_tail [NUM_QUEUES];
    logic [PW-1:0]  n_head;
    logic [PW-1:0]  n_tail;
    logic [PW-1:0]  cur_head;
    logic [PW-1:0]  cur_tail;
    logic [PW-1:0]  offset;
    logic [QIW-1:0] q_idx;
    logic           in_range;
    logic           accept;
    t_cmd_ctl       ctl;

    // Look up the addressed queue's pointers and classify the request.
    always_comb begin
        q_idx    = QIW'(i_req.queue_index);
        in_range = (int'(i_req.queue_index) < NUM_QUEUES);
        cur_head = r_head[q_idx];
        cur_tail = r_tail[q_idx];
        n_head   = cur_head + PW'(1);
        n_tail   = cur_tail + PW'(1);
        ctl      = '{status: ST_OK, wr: 1'b0, rd: 1'b0};
        offset   = cur_head;
        if (i_req.kind == KIND_ENQ) begin
            offset = cur_tail;
            if (!in_range || cur_tail == PW'(SEG_DEPTH)) begin
                ctl.status = ST_OVERFLOW;
            end else begin
                ctl.wr = 1'b1;
            end
        end else begin
            if (!in_range || cur_head >= cur_tail) begin
                ctl.status = ST_EMPTY;
            end else begin
                ctl.rd = 1'b1;
            end
        end
    end

    // Classified commands go straight into the command queue.
    assign accept       = i_req.valid && i_push_ready;
    assign i_req.ready  = i_push_ready;
    assign o_push_valid = i_req.valid;
    assign o_push_ctl   = ctl;
    assign o_push_addr  = ADDR_W'(q_idx) * ADDR_W'(SEG_DEPTH) + ADDR_W'(offset);
    assign o_push_data  = DATA_WIDTH'($unsigned(i_req.push_value));

    // Pointers only move forward; an accepted transaction updates its queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
            end
        end else if (accept) begin
            if (ctl.wr) begin
                r_tail[q_idx] <= n_tail;
            end
            if (ctl.rd) begin
                r_head[q_idx] <= n_head;
            end
        end
    end
endmodule

// File: sv/mqsb_cmd_queue.sv
module mqsb_cmd_queue #(
    parameter int ADDR_W     = 6,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push_valid,
    input  mqsb_pkg::t_cmd_ctl         i_push_ctl,
    input  logic [ADDR_W-1:0]          i_push_addr,
    input  logic [DATA_WIDTH-1:0]      i_push_data,
    output logic                       o_push_ready,
    output logic                       o_pop_valid,
    output mqsb_pkg::t_cmd_ctl         o_pop_ctl,
    output logic [ADDR_W-1:0]          o_pop_addr,
    output logic [DATA_WIDTH-1:0]      o_pop_data,
    input  logic                       i_pop_ready,
    output logic [mqsb_pkg::CQ_CW-1:0] o_count
);
    import mqsb_pkg::*;

    t_cmd_ctl              r_ctl  [CMD_DEPTH];
    logic [ADDR_W-1:0]     r_addr [CMD_DEPTH];
    logic [DATA_WIDTH-1:0] r_data [CMD_DEPTH];
    logic [CQ_AW-1:0]      r_wr_ptr;
    logic [CQ_AW-1:0]      r_rd_ptr;
    logic [CQ_CW-1:0]      r_count;
    logic [CQ_AW-1:0]      n_wr_ptr;
    logic [CQ_AW-1:0]      n_rd_ptr;
    logic                  push;
    logic                  pop;

    assign o_push_ready = (r_count != CQ_CW'(CMD_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_ctl    = r_ctl[r_rd_ptr];
    assign o_pop_addr   = r_addr[r_rd_ptr];
    assign o_pop_data   = r_data[r_rd_ptr];
    assign o_count      = r_count;

    // Pointers wrap at the queue depth.
    assign n_wr_ptr = (r_wr_ptr == CQ_AW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + CQ_AW'(1);
    assign n_rd_ptr = (r_rd_ptr == CQ_AW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + CQ_AW'(1);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ctl[r_wr_ptr]  <= i_push_ctl;
            r_addr[r_wr_ptr] <= i_push_addr;
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

    // Occupancy and pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + CQ_CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CQ_CW'(1);
            end
        end
    end
endmodule

// File: sv/mqsb_back.sv
module mqsb_back #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int SEG_DEPTH  = mqsb_pkg::SEG_DEPTH_DEF,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(NUM_QUEUES * SEG_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  mqsb_pkg::t_cmd_ctl    i_cmd_ctl,
    input  logic [ADDR_W-1:0]     i_cmd_addr,
    input  logic [DATA_WIDTH-1:0] i_cmd_data,
    output logic                  o_cmd_ready,
    mqsb_rsp_if.source            o_rsp
);
    import mqsb_pkg::*;

    localparam int STORE_DEPTH = NUM_QUEUES * SEG_DEPTH;

    logic [DATA_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    t_cmd_ctl              r_ctl;
    logic                  r_valid;
    logic                  take;

    // A command is taken whenever the response register is free or drains.
    assign o_cmd_ready = !r_valid || o_rsp.ready;
    assign take        = i_cmd_valid && o_cmd_ready;

    // Shared store: one access per command, read data registered.
    always_ff @(posedge i_clk) begin
        if (take && i_cmd_ctl.wr) begin
            r_mem[i_cmd_addr] <= i_cmd_data;
        end
        if (take && i_cmd_ctl.rd) begin
            r_rd_data <= r_mem[i_cmd_addr];
        end
        if (take) begin
            r_ctl <= i_cmd_ctl;
        end
    end

    // Response register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_ready) begin
            r_valid <= i_cmd_valid;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.status    = r_ctl.status;
    assign o_rsp.pop_value = r_ctl.rd ? $signed(POP_W'(r_rd_data)) : '0;
endmodule

// File: sv/multi_queue_shared_buffer.sv
// Several queues share one store of NUM_QUEUES * SEG_DEPTH entries, queue q
// owning the segment that starts at q * SEG_DEPTH. Each request either
// enqueues push_value at the tail of its queue or dequeues the value at its
// head; an enqueue to a queue whose tail has reached its segment end reports
// overflow, a dequeue from an empty queue reports empty, and freed space is
// not reused until reset. The block takes one request per cycle while the
// command queue has room and returns exactly one response per request, in
// order; an accepted request waits in the command queue, then the back end
// performs its store access and registers the response. That rate is set
// by the single pointer update per cycle in the front end and the single
// port of the store in the back end, with a two-entry command queue between
// them so each side can stall on its own. The store needs no clearing after
// reset: a dequeue only reads entries already written by the same queue.
module multi_queue_shared_buffer #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int SEG_DEPTH  = mqsb_pkg::SEG_DEPTH_DEF,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqsb_req_if.sink   i_req,
    mqsb_rsp_if.source o_rsp
);
    import mqsb_pkg::*;

    localparam int ADDR_W = $clog2(NUM_QUEUES * SEG_DEPTH);

    logic                  w_push_valid;
    t_cmd_ctl              w_push_ctl;
    logic [ADDR_W-1:0]     w_push_addr;
    logic [DATA_WIDTH-1:0] w_push_data;
    logic                  w_push_ready;
    logic                  w_cmd_valid;
    t_cmd_ctl              w_cmd_ctl;
    logic [ADDR_W-1:0]     w_cmd_addr;
    logic [DATA_WIDTH-1:0] w_cmd_data;
    logic                  w_cmd_ready;
    logic [CQ_CW-1:0]      w_cq_count;

    // Front end: pointer lookup and classification.
    mqsb_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .SEG_DEPTH  (SEG_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .o_push_ctl   (w_push_ctl),
        .o_push_addr  (w_push_addr),
        .o_push_data  (w_push_data),
        .i_push_ready (w_push_ready)
    );

    // Command queue between front and back.
    mqsb_cmd_queue #(
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmd_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_ctl   (w_push_ctl),
        .i_push_addr  (w_push_addr),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_cmd_valid),
        .o_pop_ctl    (w_cmd_ctl),
        .o_pop_addr   (w_cmd_addr),
        .o_pop_data   (w_cmd_data),
        .i_pop_ready  (w_cmd_ready),
        .o_count      (w_cq_count)
    );

    // Back end: store access and response register.
    mqsb_back #(
        .NUM_QUEUES (NUM_QUEUES),
        .SEG_DEPTH  (SEG_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd_ctl   (w_cmd_ctl),
        .i_cmd_addr  (w_cmd_addr),
        .i_cmd_data  (w_cmd_data),
        .o_cmd_ready (w_cmd_ready),
        .o_rsp       (o_rsp)
    );

`ifndef NO_ASSERTIONS
    // No response is offered in the cycle after reset.
    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");

    // The command queue never holds more than its depth.
    a_cq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cq_count <= CQ_CW'(CMD_DEPTH))
        else $error("command queue over its depth");

    // An accepted request lands in the command queue unless one drains.
    a_req_enqueued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !(w_cmd_valid && w_cmd_ready))
        |=> (w_cq_count == $past(w_cq_count) + CQ_CW'(1)))
        else $error("accepted request not queued");
`endif
endmodule
